### rtl/core/lev_pkg.sv
// Package for the Levenshtein edit distance block.
// Holds the sizes, command codes and controller/datapath structs.
// Used by the interfaces and by every module of the block.
package lev_pkg;

  localparam int MAX_CHARS = 64;
  localparam int CHAR_W    = 8;
  localparam int CMD_W     = 2;
  localparam int DIST_W    = 7;
  localparam int LEN_W     = $clog2(MAX_CHARS + 1);
  localparam int ADDR_W    = (MAX_CHARS > 1) ? $clog2(MAX_CHARS) : 1;
  localparam int CNT_W     = $clog2(2 * MAX_CHARS + 3);

  typedef enum logic [CMD_W-1:0] {
    CMD_APPEND_FIRST  = 2'd0,
    CMD_APPEND_SECOND = 2'd1,
    CMD_COMPUTE       = 2'd2
  } lev_cmd_e;

  // One column of the systolic cost array.
  typedef struct packed {
    logic              tok;
    logic [CHAR_W-1:0] ch;
    logic [LEN_W-1:0]  val;
    logic [LEN_W-1:0]  old;
  } lev_pe_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic              init;
    logic              wr_first;
    logic              wr_second;
    logic [ADDR_W-1:0] wr_addr;
    logic [CHAR_W-1:0] wr_char;
    logic              feed;
    logic [ADDR_W-1:0] rd_addr;
    logic [LEN_W-1:0]  sel_len;
  } lev_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [LEN_W-1:0] distance;
  } lev_stat_t;

endpackage

### rtl/core/lev_in_if.sv
// Input channel interface of the Levenshtein edit distance block.
// Depends on lev_pkg for the field widths.
interface lev_in_if
  import lev_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  cmd;
  logic [CHAR_W-1:0] char_code;

  modport source (output valid, output cmd, output char_code, input ready);
  modport sink   (input valid, input cmd, input char_code, output ready);
endinterface

### rtl/core/lev_out_if.sv
// Output channel interface of the Levenshtein edit distance block.
// Depends on lev_pkg for the field widths.
interface lev_out_if
  import lev_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [DIST_W-1:0] distance;
  logic              truncated;

  modport source (output valid, output distance, output truncated, input ready);
  modport sink   (input valid, input distance, input truncated, output ready);
endinterface

### rtl/core/lev_cell.sv
// One column cell of the systolic edit distance array.
// Depends on lev_pkg for the cell struct and widths.
module lev_cell
  import lev_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              init_i,
  input  logic [LEN_W-1:0]  init_val_i,
  input  logic [CHAR_W-1:0] b_char_i,
  input  lev_pe_t           left_i,
  output lev_pe_t           pe_o
);

  logic              tok_q;
  logic [CHAR_W-1:0] ch_q;
  logic [LEN_W-1:0]  val_q;
  logic [LEN_W-1:0]  old_q;
  logic [LEN_W-1:0]  min_val;
  logic [LEN_W-1:0]  val_d;

  always_comb begin
    min_val = val_q;
    if (left_i.val < min_val) begin
      min_val = left_i.val;
    end
    if (left_i.old < min_val) begin
      min_val = left_i.old;
    end
    if (left_i.ch == b_char_i) begin
      val_d = left_i.old;
    end else begin
      val_d = min_val + LEN_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= 1'b0;
    end else if (init_i) begin
      tok_q <= 1'b0;
    end else begin
      tok_q <= left_i.tok;
    end
  end

  always_ff @(posedge clk_i) begin
    if (init_i) begin
      val_q <= init_val_i;
    end else if (left_i.tok) begin
      old_q <= val_q;
      val_q <= val_d;
      ch_q  <= left_i.ch;
    end
  end

  assign pe_o.tok = tok_q;
  assign pe_o.ch  = ch_q;
  assign pe_o.val = val_q;
  assign pe_o.old = old_q;

endmodule

### rtl/core/lev_datapath.sv
// Datapath of the edit distance block: string buffers and systolic cost array.
// Depends on lev_pkg and instantiates lev_cell once per column.
module lev_datapath
  import lev_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  lev_cmd_t  cmd_i,
  output lev_stat_t stat_o
);

  logic [CHAR_W-1:0] first_mem [MAX_CHARS];
  logic [CHAR_W-1:0] second_q  [MAX_CHARS];
  logic [CHAR_W-1:0] rdata_q;
  logic              feed_q;
  logic              tok0_q;
  logic [CHAR_W-1:0] ch0_q;
  logic [LEN_W-1:0]  val0_q;
  logic [LEN_W-1:0]  old0_q;
  logic [LEN_W-1:0]  res_q;
  lev_pe_t           pe [MAX_CHARS+1];

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_first) begin
      first_mem[cmd_i.wr_addr] <= cmd_i.wr_char;
    end
    if (cmd_i.feed) begin
      rdata_q <= first_mem[cmd_i.rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_second) begin
      second_q[cmd_i.wr_addr] <= cmd_i.wr_char;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      feed_q <= 1'b0;
      tok0_q <= 1'b0;
    end else begin
      feed_q <= cmd_i.feed;
      tok0_q <= feed_q && !cmd_i.init;
    end
  end

  // Column zero holds the row number; it injects one character per row.
  always_ff @(posedge clk_i) begin
    if (cmd_i.init) begin
      val0_q <= '0;
    end else if (feed_q) begin
      old0_q <= val0_q;
      val0_q <= val0_q + LEN_W'(1);
      ch0_q  <= rdata_q;
    end
  end

  assign pe[0].tok = tok0_q;
  assign pe[0].ch  = ch0_q;
  assign pe[0].val = val0_q;
  assign pe[0].old = old0_q;

  for (genvar j = 1; j <= MAX_CHARS; j++) begin : g_col
    lev_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .init_i     (cmd_i.init),
      .init_val_i (LEN_W'(j)),
      .b_char_i   (second_q[j-1]),
      .left_i     (pe[j-1]),
      .pe_o       (pe[j])
    );
  end

  always_ff @(posedge clk_i) begin
    res_q <= pe[cmd_i.sel_len].val;
  end

  assign stat_o.distance = res_q;

endmodule

### rtl/core/lev_ctrl.sv
// Controller of the edit distance block: handshakes, lengths and sequencing.
// Depends on lev_pkg and the channel interfaces; drives lev_datapath.
module lev_ctrl
  import lev_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  lev_in_if.sink    in_i,
  lev_out_if.source out_o,
  output lev_cmd_t  cmd_o,
  input  lev_stat_t stat_i
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  logic              state_q, state_d;
  logic [LEN_W-1:0]  len_a_q, len_a_d;
  logic [LEN_W-1:0]  len_b_q, len_b_d;
  logic              ovf_q, ovf_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              out_valid_q, out_valid_d;
  logic              trunc_q, trunc_d;
  logic [DIST_W-1:0] dist_q, dist_d;
  logic              in_fire;
  logic [CNT_W-1:0]  end_cnt;
  logic              at_end;
  logic              finish;

  assign in_fire = in_i.valid && in_i.ready;
  assign end_cnt = CNT_W'(len_a_q) + CNT_W'(len_b_q) + CNT_W'(2);
  assign at_end  = (state_q == ST_RUN) && (cnt_q == end_cnt);
  assign finish  = at_end && (!out_valid_q || out_o.ready);

  always_comb begin
    state_d     = state_q;
    len_a_d     = len_a_q;
    len_b_d     = len_b_q;
    ovf_d       = ovf_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q;
    trunc_d     = trunc_q;
    dist_d      = dist_q;

    cmd_o           = '0;
    cmd_o.wr_char   = in_i.char_code;
    cmd_o.sel_len   = len_b_q;
    cmd_o.rd_addr   = cnt_q[ADDR_W-1:0];

    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          unique case (in_i.cmd)
            CMD_APPEND_FIRST: begin
              if (len_a_q < LEN_W'(MAX_CHARS)) begin
                cmd_o.wr_first = 1'b1;
                cmd_o.wr_addr  = len_a_q[ADDR_W-1:0];
                len_a_d        = len_a_q + LEN_W'(1);
              end else begin
                ovf_d = 1'b1;
              end
            end
            CMD_APPEND_SECOND: begin
              if (len_b_q < LEN_W'(MAX_CHARS)) begin
                cmd_o.wr_second = 1'b1;
                cmd_o.wr_addr   = len_b_q[ADDR_W-1:0];
                len_b_d         = len_b_q + LEN_W'(1);
              end else begin
                ovf_d = 1'b1;
              end
            end
            CMD_COMPUTE: begin
              cmd_o.init = 1'b1;
              cnt_d      = '0;
              state_d    = ST_RUN;
            end
            default: begin
            end
          endcase
        end
      end
      ST_RUN: begin
        cmd_o.feed = (cnt_q < CNT_W'(len_a_q));
        if (finish) begin
          out_valid_d = 1'b1;
          dist_d      = DIST_W'(stat_i.distance);
          trunc_d     = ovf_q;
          len_a_d     = '0;
          len_b_d     = '0;
          ovf_d       = 1'b0;
          state_d     = ST_IDLE;
        end else if (!at_end) begin
          cnt_d = cnt_q + CNT_W'(1);
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      len_a_q     <= '0;
      len_b_q     <= '0;
      ovf_q       <= 1'b0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      len_a_q     <= len_a_d;
      len_b_q     <= len_b_d;
      ovf_q       <= ovf_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    trunc_q <= trunc_d;
    dist_q  <= dist_d;
  end

  assign in_i.ready      = (state_q == ST_IDLE);
  assign out_o.valid     = out_valid_q;
  assign out_o.distance  = dist_q;
  assign out_o.truncated = trunc_q;

  a_compute_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && (in_i.cmd == CMD_COMPUTE) |=> (state_q == ST_RUN) && (cnt_q == '0))
    else $error("compute transaction did not start the sweep");

  a_cnt_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RUN) |-> (cnt_q <= end_cnt))
    else $error("sweep counter ran past the end of the sweep");

  a_finish_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    finish |=> (len_a_q == '0) && (len_b_q == '0) && !ovf_q && out_valid_q)
    else $error("finished sweep did not clear the strings or post a result");

  a_feed_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.feed |-> (state_q == ST_RUN) && (cnt_q < CNT_W'(len_a_q)))
    else $error("character fed outside the first string");

endmodule

### rtl/core/levenshtein_edit_distance.sv
// Levenshtein edit distance between two byte strings of up to MAX_CHARS bytes.
// Top level; depends on lev_pkg, lev_in_if, lev_out_if, lev_ctrl, lev_datapath.
//
// The input channel carries one transaction per command. Command append-first
// or append-second stores char_code at the end of that string;
// a byte past capacity is dropped and sets the truncation flag. Command
// compute runs a systolic sweep: one column cell per character of the second
// string, with the first string streamed in one character per cycle. The
// result of a compute transaction is posted once the wavefront has crossed
// the cell array. Unused command codes are accepted and ignored. No input
// is taken during a sweep.
// The result (distance, truncated) sits in an output register; appends are
// still accepted while it waits. If the receiver stalls at the end of a
// sweep, the sweep holds its result until the output register is free.
// Reset empties both strings, clears the flag and drops any pending result.
module levenshtein_edit_distance
  import lev_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  lev_in_if.sink    in_i,
  lev_out_if.source out_o
);

  lev_cmd_t  cmd;
  lev_stat_t stat;

  lev_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .out_o  (out_o),
    .cmd_o  (cmd),
    .stat_i (stat)
  );

  lev_datapath u_datapath (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .stat_o (stat)
  );

endmodule
